@@ hw/rtl/prime_sieve_atkin_core_assert.svh @@
// Assertion macros shared by the sieve core.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef PRIME_SIEVE_ATKIN_CORE_ASSERT_SVH
`define PRIME_SIEVE_ATKIN_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PSA_ASSERT_ALWAYS(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("psa assertion failed");

`define PSA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("psa assertion failed");

`define PSA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("psa assertion failed");

`else

`define PSA_ASSERT_ALWAYS(name, clk, rstn, expr)
`define PSA_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define PSA_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/psa_pkg.sv @@
package psa_pkg;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [15:0] UPPER_LIMIT_RST = 16'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_build;
    logic query_rd;
    logic clr_wr;
    logic tog_rd;
    logic tog_wr;
    logic tog_adv;
    logic next_x;
    logic sq_rd;
    logic sq_start_mul;
    logic sq_next_i;
    logic sq_wr;
    logic set_built;
    logic load_out;
  } psa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic x_done;
    logic y_done;
    logic cand_hit;
    logic sq_done;
    logic sq_bit;
    logic m_done;
    logic slot_free;
  } psa_stat_t;

endpackage

@@ hw/rtl/psa_datapath.sv @@
module psa_datapath #(
  parameter int unsigned MaxNumber = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psa_pkg::psa_cmd_t   cmd_i,
  output psa_pkg::psa_stat_t  stat_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [15:0]         in_num_i,
  input  logic                out_taken_i,
  output logic                out_valid_o,
  output logic                out_prime_flag_o,
  output logic                out_ready_res_o
);

  // Numbers are 16 bits wide, so no more than 65536 bitmap entries are reachable.
  localparam int unsigned DEPTH = (MaxNumber < 65536) ? MaxNumber : 65536;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [15:0] BOUND_MAX = 16'(DEPTH - 1);

  localparam logic [3:0] RES_4X_LO    = 4'd1;
  localparam logic [3:0] RES_4X_HI    = 4'd5;
  localparam logic [3:0] RES_3X_PLUS  = 4'd7;
  localparam logic [3:0] RES_3X_MINUS = 4'd11;
  localparam logic [5:0] MOD_BASE     = 6'd12;

  typedef enum logic [1:0] {
    CAND_4X,
    CAND_3X_PLUS,
    CAND_3X_MINUS
  } cand_e;

  function automatic logic [3:0] mod12(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd48) r = r - 6'd48;
    if (r >= 6'd24) r = r - 6'd24;
    if (r >= MOD_BASE) r = r - MOD_BASE;
    return r[3:0];
  endfunction

  logic [15:0] upper_limit_q;
  logic [15:0] lim_q;
  logic [15:0] built_bound_q;
  logic        built_q;
  logic        op_q;
  logic [15:0] num_q;
  logic [15:0] clr_q;
  logic [8:0]  x_q;
  logic [16:0] xx_q;
  logic [3:0]  xm_q;
  logic [3:0]  xxm_q;
  logic [8:0]  y_q;
  logic [16:0] yy_q;
  logic [3:0]  ym_q;
  logic [3:0]  yym_q;
  cand_e       cand_q;
  logic [8:0]  i_q;
  logic [16:0] ii_q;
  logic [16:0] m_q;
  logic        rd_q;
  logic        out_valid_q;
  logic        out_prime_q;
  logic        out_rdy_q;

  logic bitmap_mem [DEPTH];

  logic [15:0] eff_bound;
  logic [18:0] n_4x;
  logic [18:0] n_3x;
  logic [18:0] n_plus;
  logic [18:0] n_minus;
  logic [5:0]  xxm3;
  logic [3:0]  r_4x;
  logic [3:0]  r_plus;
  logic [3:0]  r_minus;
  logic [18:0] cand_n;
  logic        res_ok;
  logic [16:0] xx_next;
  logic [16:0] yy_next;
  logic [3:0]  xm_next;
  logic [3:0]  ym_next;
  logic [3:0]  xxm_next;
  logic [3:0]  yym_next;
  logic [16:0] ii_next;
  logic        q_prime;
  logic        res_prime;
  logic          mem_we;
  logic          mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  assign eff_bound = (upper_limit_q > BOUND_MAX) ? BOUND_MAX : upper_limit_q;

  // Candidate values for the current x, y pair.
  assign n_4x    = {xx_q, 2'b00} + 19'(yy_q);
  assign n_3x    = 19'({xx_q, 1'b0}) + 19'(xx_q);
  assign n_plus  = n_3x + 19'(yy_q);
  assign n_minus = n_3x - 19'(yy_q);

  // Residues mod 12 come from the tracked square residues, not from n itself.
  assign xxm3    = 6'({xxm_q, 1'b0}) + 6'(xxm_q);
  assign r_4x    = mod12({xxm_q, 2'b00} + 6'(yym_q));
  assign r_plus  = mod12(xxm3 + 6'(yym_q));
  assign r_minus = mod12(xxm3 + MOD_BASE - 6'(yym_q));

  always_comb begin
    case (cand_q)
      CAND_4X: begin
        cand_n = n_4x;
        res_ok = (r_4x == RES_4X_LO) || (r_4x == RES_4X_HI);
      end
      CAND_3X_PLUS: begin
        cand_n = n_plus;
        res_ok = (r_plus == RES_3X_PLUS);
      end
      CAND_3X_MINUS: begin
        cand_n = n_minus;
        res_ok = (r_minus == RES_3X_MINUS) && (x_q > y_q);
      end
      default: begin
        cand_n = n_4x;
        res_ok = 1'b0;
      end
    endcase
  end

  // (k+1)^2 = k^2 + 2k + 1, with the residues stepped alongside.
  assign xx_next  = xx_q + 17'({x_q, 1'b0}) + 17'd1;
  assign yy_next  = yy_q + 17'({y_q, 1'b0}) + 17'd1;
  assign xm_next  = (xm_q == RES_3X_MINUS) ? 4'd0 : xm_q + 4'd1;
  assign ym_next  = (ym_q == RES_3X_MINUS) ? 4'd0 : ym_q + 4'd1;
  assign xxm_next = mod12(6'(xxm_q) + 6'({xm_q, 1'b0}) + 6'd1);
  assign yym_next = mod12(6'(yym_q) + 6'({ym_q, 1'b0}) + 6'd1);
  assign ii_next  = ii_q + 17'({i_q, 1'b0}) + 17'd1;

  // Bits above the bound of the last build were not cleared by it and never count.
  assign q_prime = built_q && (num_q <= eff_bound) &&
                   ((num_q == 16'd2) || (num_q == 16'd3) ||
                    ((num_q >= 16'd5) && (num_q <= built_bound_q) && rd_q));
  assign res_prime = (op_q == psa_pkg::OP_QUERY) && q_prime;

  assign stat_o.clr_last  = (clr_q == lim_q);
  assign stat_o.x_done    = (xx_q > 17'(lim_q));
  assign stat_o.y_done    = (yy_q > 17'(lim_q));
  assign stat_o.cand_hit  = res_ok && (cand_n <= 19'(lim_q));
  assign stat_o.sq_done   = (ii_q > 17'(lim_q));
  assign stat_o.sq_bit    = rd_q;
  assign stat_o.m_done    = (m_q > 17'(lim_q));
  assign stat_o.slot_free = !out_valid_q || out_taken_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_waddr = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd_i.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(clr_q);
    end else if (cmd_i.tog_wr) begin
      mem_we    = 1'b1;
      mem_wdata = ~rd_q;
      mem_waddr = AW'(cand_n);
    end else if (cmd_i.sq_wr) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(m_q);
    end
    if (cmd_i.query_rd) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(in_num_i);
    end else if (cmd_i.tog_rd) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(cand_n);
    end else if (cmd_i.sq_rd) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(i_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= bitmap_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_limit_q <= psa_pkg::UPPER_LIMIT_RST;
      built_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) upper_limit_q <= cfg_data_i;
      if (cmd_i.set_built) built_q <= 1'b1;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_taken_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_build) begin
      lim_q  <= eff_bound;
      op_q   <= psa_pkg::OP_BUILD;
      clr_q  <= '0;
      x_q    <= 9'd1;
      xx_q   <= 17'd1;
      xm_q   <= 4'd1;
      xxm_q  <= 4'd1;
      y_q    <= 9'd1;
      yy_q   <= 17'd1;
      ym_q   <= 4'd1;
      yym_q  <= 4'd1;
      cand_q <= CAND_4X;
      i_q    <= 9'd5;
      ii_q   <= 17'd25;
    end
    if (cmd_i.query_rd) begin
      op_q  <= psa_pkg::OP_QUERY;
      num_q <= in_num_i;
    end
    if (cmd_i.clr_wr) clr_q <= clr_q + 16'd1;
    if (cmd_i.next_x) begin
      x_q    <= x_q + 9'd1;
      xx_q   <= xx_next;
      xm_q   <= xm_next;
      xxm_q  <= xxm_next;
      y_q    <= 9'd1;
      yy_q   <= 17'd1;
      ym_q   <= 4'd1;
      yym_q  <= 4'd1;
      cand_q <= CAND_4X;
    end
    if (cmd_i.tog_adv) begin
      case (cand_q)
        CAND_4X:      cand_q <= CAND_3X_PLUS;
        CAND_3X_PLUS: cand_q <= CAND_3X_MINUS;
        CAND_3X_MINUS: begin
          cand_q <= CAND_4X;
          y_q    <= y_q + 9'd1;
          yy_q   <= yy_next;
          ym_q   <= ym_next;
          yym_q  <= yym_next;
        end
        default: cand_q <= CAND_4X;
      endcase
    end
    if (cmd_i.sq_next_i) begin
      i_q  <= i_q + 9'd1;
      ii_q <= ii_next;
    end
    if (cmd_i.sq_start_mul) m_q <= ii_q;
    if (cmd_i.sq_wr) m_q <= m_q + ii_q;
    if (cmd_i.set_built) built_bound_q <= lim_q;
    if (cmd_i.load_out) begin
      out_prime_q <= res_prime;
      out_rdy_q   <= built_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_prime_flag_o = out_prime_q;
  assign out_ready_res_o  = out_rdy_q;

endmodule

@@ hw/rtl/psa_ctrl.sv @@
module psa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  psa_pkg::psa_stat_t  stat_i,
  output psa_pkg::psa_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TOG_CHK,
    ST_TOG_WR,
    ST_SQ_CHK,
    ST_SQ_TEST,
    ST_SQ_CLR,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == psa_pkg::OP_BUILD) begin
            cmd_o.start_build = 1'b1;
            state_d           = ST_CLEAR;
          end else begin
            cmd_o.query_rd = 1'b1;
            state_d        = ST_RESP;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = ST_TOG_CHK;
      end
      ST_TOG_CHK: begin
        if (stat_i.x_done) begin
          state_d = ST_SQ_CHK;
        end else if (stat_i.y_done) begin
          cmd_o.next_x = 1'b1;
        end else if (stat_i.cand_hit) begin
          cmd_o.tog_rd = 1'b1;
          state_d      = ST_TOG_WR;
        end else begin
          cmd_o.tog_adv = 1'b1;
        end
      end
      ST_TOG_WR: begin
        // The read data of the candidate bit is back; write its complement.
        cmd_o.tog_wr  = 1'b1;
        cmd_o.tog_adv = 1'b1;
        state_d       = ST_TOG_CHK;
      end
      ST_SQ_CHK: begin
        if (stat_i.sq_done) begin
          cmd_o.set_built = 1'b1;
          state_d         = ST_RESP;
        end else begin
          cmd_o.sq_rd = 1'b1;
          state_d     = ST_SQ_TEST;
        end
      end
      ST_SQ_TEST: begin
        if (stat_i.sq_bit) begin
          cmd_o.sq_start_mul = 1'b1;
          state_d            = ST_SQ_CLR;
        end else begin
          cmd_o.sq_next_i = 1'b1;
          state_d         = ST_SQ_CHK;
        end
      end
      ST_SQ_CLR: begin
        if (stat_i.m_done) begin
          cmd_o.sq_next_i = 1'b1;
          state_d         = ST_SQ_CHK;
        end else begin
          cmd_o.sq_wr = 1'b1;
        end
      end
      ST_RESP: begin
        if (stat_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/prime_sieve_atkin_core.sv @@
// Channel   Direction  tdata (low bit up)                  tuser
// s_axis    in         number[15:0]                        operation
// m_axis    out        prime_flag, ready_res, zero[7:2]    -
// cfg       in         upper_limit[15:0]                   -
//
// A query does one bitmap read, then loads the output register once it is free.
// A build clears entries 0..B (B the bound), checks the three candidates of each (x, y)
// pair and toggles the bits that hit, then checks and tests each square root candidate i
// and clears the multiples of i*i for each flagged i, then closes the loops and loads the result.
// The bitmap has no reset; it is defined by the first build. The output register
// lets a new request in while a result waits on m_axis_tready_i.
module prime_sieve_atkin_core #(
  parameter int unsigned MAX_NUMBER = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // number[15:0]
  input  logic [0:0]  s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // prime_flag, ready_res, zero[7:2]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i        // upper_limit[15:0]
);

  `include "prime_sieve_atkin_core_assert.svh"

  psa_pkg::psa_cmd_t  cmd;
  psa_pkg::psa_stat_t stat;
  logic               out_valid;
  logic               out_prime_flag;
  logic               out_ready_res;
  logic               in_accept;
  logic               mem_wr_cmd;
  logic               mem_rd_cmd;

  assign cfg_ready_o = 1'b1;

  psa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psa_datapath #(
    .MaxNumber (MAX_NUMBER)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_num_i         (s_axis_tdata_i),
    .out_taken_i      (m_axis_tvalid_o && m_axis_tready_i),
    .out_valid_o      (out_valid),
    .out_prime_flag_o (out_prime_flag),
    .out_ready_res_o  (out_ready_res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {6'b0, out_ready_res, out_prime_flag};

  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign mem_wr_cmd = cmd.clr_wr || cmd.tog_wr || cmd.sq_wr;
  assign mem_rd_cmd = cmd.query_rd || cmd.tog_rd || cmd.sq_rd;

  `PSA_ASSERT_IMPL(a_prime_needs_sieve, clk_i, rst_ni, out_valid && out_prime_flag, out_ready_res)
  `PSA_ASSERT_NEXT(a_accept_then_busy, clk_i, rst_ni, in_accept, !s_axis_tready_o)
  `PSA_ASSERT_ALWAYS(a_single_port, clk_i, rst_ni, !(mem_wr_cmd && mem_rd_cmd))
  `PSA_ASSERT_NEXT(a_load_shows_result, clk_i, rst_ni, cmd.load_out, m_axis_tvalid_o)

endmodule

@@ test/prime_sieve_atkin_core_test.sv @@
module prime_sieve_atkin_core_test;

  localparam int unsigned MAP_SIZE = 65536;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int PLAN_LEN = 30;

  typedef enum logic {
    ROW_ITEM,
    ROW_LIMIT
  } row_kind_e;

  // A directed row either sends one request or rewrites the bound.
  typedef struct packed {
    row_kind_e   kind;
    logic        op;
    logic [15:0] value;
    logic        typed;
    logic        prime;
    logic        built;
  } plan_row_t;

  typedef struct packed {
    logic prime;
    logic built;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  // Model of the block's state.
  bit          sieve_map [MAP_SIZE];
  bit          map_built;
  logic [15:0] bound_reg;

  verdict_t    pending_verdicts [$];
  plan_row_t   plan [PLAN_LEN];
  int unsigned err_count;
  int unsigned result_count;
  int unsigned sent_count;
  bit          burst;
  int unsigned stall_left;
  int unsigned stall_draw;
  verdict_t    want;

  prime_sieve_atkin_core #(
    .MAX_NUMBER(MAP_SIZE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned sieve_bound();
    int unsigned b;
    b = bound_reg;
    if (b > MAP_SIZE - 1) b = MAP_SIZE - 1;
    return b;
  endfunction

  function automatic void build_sieve_map();
    int unsigned lim, x, y, n, i, m, sq;
    lim = sieve_bound();
    foreach (sieve_map[k]) sieve_map[k] = 1'b0;
    for (x = 1; x * x <= lim; x++) begin
      for (y = 1; y * y <= lim; y++) begin
        n = 4 * x * x + y * y;
        if (n <= lim && (n % 12 == 1 || n % 12 == 5)) sieve_map[n] = ~sieve_map[n];
        n = 3 * x * x + y * y;
        if (n <= lim && n % 12 == 7) sieve_map[n] = ~sieve_map[n];
        if (x > y) begin
          n = 3 * x * x - y * y;
          if (n <= lim && n % 12 == 11) sieve_map[n] = ~sieve_map[n];
        end
      end
    end
    for (i = 5; i * i <= lim; i++) begin
      if (sieve_map[i]) begin
        sq = i * i;
        for (m = sq; m <= lim; m += sq) sieve_map[m] = 1'b0;
      end
    end
    map_built = 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(logic op, logic [15:0] num);
    verdict_t v;
    v.prime = 1'b0;
    if (op == psa_pkg::OP_BUILD) begin
      build_sieve_map();
    end else if (map_built && num <= sieve_bound()) begin
      if (num == 16'd2 || num == 16'd3) v.prime = 1'b1;
      else if (num >= 16'd5) v.prime = sieve_map[num];
    end
    v.built = map_built;
    return v;
  endfunction

  // The request that was just accepted leaves tvalid high; every caller lowers it
  // or replaces the request in that same step.
  task automatic send_request(input logic op, input logic [15:0] num, input logic typed,
                              input verdict_t typed_verdict);
    int unsigned gap;
    verdict_t v;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= num;
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    v = predict_verdict(op, num);
    pending_verdicts.push_back(typed ? typed_verdict : v);
    sent_count++;
  endtask

  task automatic send_checked(input logic op, input logic [15:0] num);
    send_request(op, num, 1'b0, '0);
  endtask

  // The bound is only rewritten once every result has been taken.
  task automatic write_bound(input logic [15:0] val);
    s_axis_tvalid_i <= 1'b0;
    wait (pending_verdicts.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bound_reg = val;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_verdicts.size() == 0) begin
          if (err_count < 10)
            $display("result %0d arrived with no request waiting: tdata %h",
                     result_count, m_axis_tdata_o);
          err_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (m_axis_tdata_o[0] !== want.prime || m_axis_tdata_o[1] !== want.built ||
              m_axis_tdata_o[7:2] !== 6'd0) begin
            if (err_count < 10)
              $display({"result %0d mismatch: prime_flag exp %0b got %0b, ",
                        "ready_res exp %0b got %0b, pad got %h"},
                       result_count, want.prime, m_axis_tdata_o[0], want.built,
                       m_axis_tdata_o[1], m_axis_tdata_o[7:2]);
            err_count++;
          end
        end
        result_count++;
        stall_draw = burst ? 0 : $urandom_range(0, 11);
        stall_left <= stall_draw;
        m_axis_tready_i <= (stall_draw == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready_i <= (stall_left == 1);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(64'd100_000_000);
    $display("prime_sieve_atkin_core_test: done, errors");
    $finish;
  end

  initial begin
    int unsigned lim, nq, r, pick, top;
    plan = '{
      // Before any build even 2 and 3 read as not prime.
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd2,     1'b1, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd3,     1'b1, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd0,     1'b1, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd65535, 1'b1, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_BUILD, 16'd65535, 1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd2,     1'b1, 1'b1, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd3,     1'b1, 1'b1, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd0,     1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd1,     1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd4,     1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd5,     1'b1, 1'b1, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd997,   1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd1000,  1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd1001,  1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd65535, 1'b1, 1'b0, 1'b1},
      // Raising the bound does not extend the last build.
      '{ROW_LIMIT, psa_pkg::OP_BUILD, 16'd65535, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd1009,  1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_BUILD, 16'd0,     1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd65521, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd65535, 1'b0, 1'b0, 1'b0},
      '{ROW_LIMIT, psa_pkg::OP_BUILD, 16'd2,     1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_BUILD, 16'h5555,  1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd2,     1'b1, 1'b1, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd3,     1'b1, 1'b0, 1'b1},
      // With a bound below 2 nothing can be prime.
      '{ROW_LIMIT, psa_pkg::OP_BUILD, 16'd0,     1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_BUILD, 16'hAAAA,  1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd0,     1'b1, 1'b0, 1'b1},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd2,     1'b1, 1'b0, 1'b1},
      '{ROW_LIMIT, psa_pkg::OP_BUILD, 16'd1,     1'b0, 1'b0, 1'b0},
      '{ROW_ITEM,  psa_pkg::OP_QUERY, 16'd1,     1'b1, 1'b0, 1'b1}
    };
    foreach (sieve_map[k]) sieve_map[k] = 1'b0;
    map_built = 1'b0;
    bound_reg = psa_pkg::UPPER_LIMIT_RST;
    err_count = 0;
    result_count = 0;
    sent_count = 0;
    burst = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[idx]) begin
      if (plan[idx].kind == ROW_LIMIT)
        write_bound(plan[idx].value);
      else
        send_request(plan[idx].op, plan[idx].value, plan[idx].typed,
                     '{prime: plan[idx].prime, built: plan[idx].built});
    end

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      // Mostly small bounds keep builds short; a few larger ones and a few below 2.
      pick = $urandom_range(0, 99);
      if (pick < 5) lim = $urandom_range(0, 1);
      else if (pick < 85) lim = $urandom_range(2, 600);
      else lim = $urandom_range(601, 4000);
      write_bound(lim[15:0]);
      // Now and then the phase queries the previous build under the new bound.
      if ($urandom_range(0, 7) != 0) send_checked(psa_pkg::OP_BUILD, 16'($urandom));
      nq = $urandom_range(20, 60);
      top = (lim + 4 > 65535) ? 65535 : lim + 4;
      repeat (nq) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_checked(psa_pkg::OP_BUILD, 16'($urandom));
        else if (r < 78) send_checked(psa_pkg::OP_QUERY, 16'($urandom_range(0, top)));
        else if (r < 88) send_checked(psa_pkg::OP_QUERY, 16'($urandom_range(0, 12)));
        else send_checked(psa_pkg::OP_QUERY, 16'($urandom));
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0)
      $display("prime_sieve_atkin_core_test: done, clean");
    else
      $display("prime_sieve_atkin_core_test: done, errors");
    $finish;
  end

endmodule

@@ prime_sieve_atkin_core.f @@
+incdir+hw/rtl
hw/rtl/psa_pkg.sv
hw/rtl/psa_datapath.sv
hw/rtl/psa_ctrl.sv
hw/rtl/prime_sieve_atkin_core.sv
test/prime_sieve_atkin_core_test.sv
